// ----- src/cmt_pkg.sv -----
// ----------------------------------------------------------------------------
// cmt_pkg
// Shared types for the cube move command translator: accumulator, translator
// state and result item.
// ----------------------------------------------------------------------------
package cmt_pkg;

	localparam int Q_DEPTH   = 4;
	localparam int MAX_RES   = 3;

	// One near face (U L F) and one far face (R D B) of one axis.
	typedef struct packed {
		logic [2:0] near_face;
		logic [1:0] near_turns;
		logic [2:0] far_face;
		logic [1:0] far_turns;
	} accum_t;

	typedef struct packed {
		logic       pend_valid;
		logic [2:0] pend_face;
		accum_t     acc;
	} xlat_state_t;

	typedef struct packed {
		logic [7:0] command_byte;
		logic       bad_char;
		logic       run_end;
	} result_t;

endpackage

// ----- src/cmt_step.sv -----
// ----------------------------------------------------------------------------
// cmt_step
// Parse one character against the current state: suffix handling, up to two
// turn merges, error detection and end-of-text flush. Pure combinational.
// ----------------------------------------------------------------------------
module cmt_step import cmt_pkg::*; (
	input  logic [7:0]  char_in,
	input  logic        end_of_text,
	input  xlat_state_t cur,
	output xlat_state_t nxt,
	output result_t     res [MAX_RES],
	output logic [1:0]  res_n
);

	localparam logic [2:0] FACE_U = 3'd0;
	localparam logic [2:0] FACE_R = 3'd1;
	localparam logic [2:0] FACE_F = 3'd2;
	localparam logic [2:0] FACE_D = 3'd3;
	localparam logic [2:0] FACE_L = 3'd4;
	localparam logic [2:0] FACE_B = 3'd5;

	localparam logic [7:0] CH_U     = 8'h55;
	localparam logic [7:0] CH_R     = 8'h52;
	localparam logic [7:0] CH_F     = 8'h46;
	localparam logic [7:0] CH_D     = 8'h44;
	localparam logic [7:0] CH_L     = 8'h4C;
	localparam logic [7:0] CH_B     = 8'h42;
	localparam logic [7:0] CASE_OFS = 8'h20;
	localparam logic [7:0] CH_ONE   = 8'h31;
	localparam logic [7:0] CH_PLUS  = 8'h2B;
	localparam logic [7:0] CH_TWO   = 8'h32;
	localparam logic [7:0] CH_PRIME = 8'h27;
	localparam logic [7:0] CH_THREE = 8'h33;
	localparam logic [7:0] CH_MINUS = 8'h2D;
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_TAB   = 8'h09;
	localparam logic [7:0] CH_CR    = 8'h0D;

	localparam logic [7:0] BASE_UD  = 8'h45;  // 'E'
	localparam logic [7:0] BASE_LR  = 8'h70;  // 'p'
	localparam logic [7:0] BASE_LR2 = 8'h41;  // 'A'
	localparam logic [7:0] BASE_FB  = 8'h61;  // 'a'
	localparam logic [3:0] LR_SPLIT = 4'd11;

	typedef struct packed {
		accum_t     acc;
		logic       emit;
		logic [7:0] code;
	} merge_t;

	function automatic logic [1:0] face_axis(input logic [2:0] f);
		logic [1:0] a;
		case (f) inside
			3'd0, 3'd3, 3'd6: a = 2'd0;
			3'd1, 3'd4, 3'd7: a = 2'd1;
			default:          a = 2'd2;
		endcase
		return a;
	endfunction

	function automatic logic [7:0] accum_code(input accum_t a);
		logic [1:0] axis;
		logic [3:0] idx;
		logic [3:0] near_part;
		logic [7:0] c;
		axis = (a.near_turns != 2'd0) ? face_axis(a.near_face) : face_axis(a.far_face);
		if (a.far_turns == 2'd0) begin
			idx = {2'b00, a.near_turns} - 4'd1;
		end else begin
			near_part = (a.near_turns == 2'd0) ? 4'd3 : ({2'b00, a.near_turns} - 4'd1);
			idx = 4'd3 + {a.far_turns - 2'd1, 2'b00} + near_part;
		end
		if (idx == 4'd15) idx = 4'd14;
		case (axis)
			2'd0:    c = BASE_UD + {4'd0, idx};
			2'd1:    c = (idx < LR_SPLIT) ? (BASE_LR + {4'd0, idx})
			                              : (BASE_LR2 + {4'd0, idx - LR_SPLIT});
			default: c = BASE_FB + {4'd0, idx};
		endcase
		return c;
	endfunction

	function automatic merge_t merge_turn(input accum_t a, input logic [2:0] f,
	                                      input logic [1:0] t);
		merge_t     m;
		logic       is_near;
		logic [1:0] axis;
		logic       fail;
		accum_t     b;
		is_near = (f == FACE_U) || (f == FACE_F) || (f == FACE_L);
		axis    = face_axis(f);
		if (is_near)
			fail = ((a.near_turns != 2'd0) && (a.near_face != f)) ||
			       ((a.far_turns != 2'd0) && (face_axis(a.far_face) != axis));
		else
			fail = ((a.far_turns != 2'd0) && (a.far_face != f)) ||
			       ((a.near_turns != 2'd0) && (face_axis(a.near_face) != axis));
		m.emit = fail;
		m.code = accum_code(a);
		b = fail ? '0 : a;
		if (is_near) begin
			if (b.near_turns == 2'd0) begin
				b.near_face  = f;
				b.near_turns = t;
			end else begin
				b.near_turns = b.near_turns + t;
				if (b.near_turns == 2'd0) b.near_face = 3'd0;
			end
		end else begin
			if (b.far_turns == 2'd0) begin
				b.far_face  = f;
				b.far_turns = t;
			end else begin
				b.far_turns = b.far_turns + t;
				if (b.far_turns == 2'd0) b.far_face = 3'd0;
			end
		end
		m.acc = b;
		return m;
	endfunction

	logic [1:0] suf_turns;
	logic       up_ok, low_ok, space;
	logic [2:0] up_face, low_face;
	merge_t     m1, m2;
	accum_t     acc_a, acc_b;
	logic       used, consider, err, en2, e1, e2, flush;
	logic [2:0] face2;
	result_t    cand [MAX_RES];
	logic [MAX_RES-1:0] cand_v;

	always_comb begin
		case (char_in) inside
			CH_ONE, CH_PLUS:             suf_turns = 2'd1;
			CH_TWO:                      suf_turns = 2'd2;
			CH_PRIME, CH_THREE, CH_MINUS: suf_turns = 2'd3;
			default:                     suf_turns = 2'd0;
		endcase
		up_ok = 1'b1;
		unique case (char_in)
			CH_U:    up_face = FACE_U;
			CH_R:    up_face = FACE_R;
			CH_F:    up_face = FACE_F;
			CH_D:    up_face = FACE_D;
			CH_L:    up_face = FACE_L;
			CH_B:    up_face = FACE_B;
			default: begin
				up_face = 3'd0;
				up_ok   = 1'b0;
			end
		endcase
		low_ok = 1'b1;
		unique case (char_in)
			CH_U + CASE_OFS: low_face = FACE_U;
			CH_R + CASE_OFS: low_face = FACE_R;
			CH_F + CASE_OFS: low_face = FACE_F;
			CH_D + CASE_OFS: low_face = FACE_D;
			CH_L + CASE_OFS: low_face = FACE_L;
			CH_B + CASE_OFS: low_face = FACE_B;
			default: begin
				low_face = 3'd0;
				low_ok   = 1'b0;
			end
		endcase
		space = (char_in == CH_SPACE) || ((char_in >= CH_TAB) && (char_in <= CH_CR));
	end

	always_comb begin
		// open face letter: a suffix completes it, anything else closes it as a quarter turn
		m1    = merge_turn(cur.acc, cur.pend_face, (suf_turns != 2'd0) ? suf_turns : 2'd1);
		acc_a = cur.pend_valid ? m1.acc : cur.acc;
		e1    = cur.pend_valid & m1.emit;
		used  = cur.pend_valid & (suf_turns != 2'd0);

		consider = !used && !space;
		err      = consider && !up_ok && !low_ok;
		en2      = consider && (low_ok || (up_ok && end_of_text));
		face2    = low_ok ? low_face : up_face;
		m2       = merge_turn(acc_a, face2, low_ok ? 2'd3 : 2'd1);
		acc_b    = en2 ? m2.acc : acc_a;
		e2       = en2 & m2.emit;
		flush    = end_of_text && !err &&
		           ((acc_b.near_turns != 2'd0) || (acc_b.far_turns != 2'd0));

		if (err || end_of_text) begin
			nxt = '0;
		end else begin
			nxt.pend_valid = consider && up_ok;
			nxt.pend_face  = (consider && up_ok) ? up_face : 3'd0;
			nxt.acc        = acc_b;
		end

		cand[0] = '{command_byte: m1.code, bad_char: 1'b0, run_end: 1'b0};
		cand[1] = '{command_byte: err ? 8'd0 : m2.code, bad_char: err, run_end: 1'b0};
		cand[2] = '{command_byte: accum_code(acc_b), bad_char: 1'b0, run_end: 1'b0};
		cand_v  = {flush, e2 | err, e1};

		// pack the results that exist into the low slots, mark the final one
		for (int i = 0; i < MAX_RES; i++) res[i] = '0;
		res_n = 2'd0;
		for (int i = 0; i < MAX_RES; i++) begin
			if (cand_v[i]) begin
				res[res_n] = cand[i];
				res_n      = res_n + 2'd1;
			end
		end
		if (res_n != 2'd0) res[res_n - 2'd1].run_end = 1'b1;
	end

endmodule

// ----- src/cmt_queue.sv -----
// ----------------------------------------------------------------------------
// cmt_queue
// Shift-register result queue: up to three pushes and one pop per cycle,
// head entry drives the output directly.
// ----------------------------------------------------------------------------
module cmt_queue import cmt_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  result_t    push_data [MAX_RES],
	input  logic [1:0] push_n,
	input  logic       pop,
	output result_t    head,
	output logic [2:0] count
);

	result_t    q_q [Q_DEPTH];
	result_t    q_d [Q_DEPTH];
	logic [2:0] count_q;
	logic [2:0] keep;
	logic [2:0] k;

	always_comb begin
		k    = 3'd0;
		keep = count_q - {2'b00, pop};
		for (int i = 0; i < Q_DEPTH; i++) begin
			q_d[i] = q_q[i];
			if (3'(i) < keep) begin
				if (pop && (i < Q_DEPTH - 1)) q_d[i] = q_q[(i + 1) % Q_DEPTH];
			end else begin
				k = 3'(i) - keep;
				if (k < {1'b0, push_n}) q_d[i] = push_data[k[1:0]];
			end
		end
	end

	always_ff @(posedge clk) begin
		q_q <= q_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= 3'd0;
		end else begin
			count_q <= keep + {1'b0, push_n};
		end
	end

	assign head  = q_q[0];
	assign count = count_q;

endmodule

// ----- src/cube_move_command_translator.sv -----
// ----------------------------------------------------------------------------
// cube_move_command_translator
// Turns cube move notation, one character per item, into machine command
// characters, merging consecutive turns of one axis into a single command.
// ----------------------------------------------------------------------------
// Usage: feed one ASCII character per item on the s_ side, with s_tlast on the
// final character of a string. Face letters U R F D L B take an optional
// suffix (1 or + quarter, 2 half, ' 3 or - counter-clockwise); lowercase
// letters are counter-clockwise quarter turns; whitespace is skipped between
// turns. Turns on one axis accumulate (same face adds mod 4, opposite faces
// pair), and a turn that does not fit pushes out the pending command as one
// byte a..z / A..S. s_tlast flushes everything. Any other character yields an
// error item (tdata 0, tuser 1) and drops all accumulated turns. One
// character can give up to three result items; m_tlast marks the last of
// them. Timing: the block takes one character per cycle while s_tready is
// high. A character lands in an input register and is parsed and merged
// there once the queue has room; its results go to a four-entry queue
// whose head drives m_ and that drains one item per cycle while m_tready
// is high, so a character with more than one result, or a stalled m_tready,
// holds s_tready low until no more than one result is waiting.
// ----------------------------------------------------------------------------
module cube_move_command_translator import cmt_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       s_tvalid,
	output logic       s_tready,
	input  logic [7:0] s_tdata,   // [7:0] char_in
	input  logic       s_tlast,   // end_of_text
	output logic       m_tvalid,
	input  logic       m_tready,
	output logic [7:0] m_tdata,   // [7:0] command_byte
	output logic       m_tuser,   // [0] bad_char
	output logic       m_tlast    // run_end
);

	// input register
	logic        v_s1;
	logic [7:0]  char_s1;
	logic        end_s1;

	// translator state, advanced only when a stage-1 item retires
	xlat_state_t state_q;
	xlat_state_t state_d;

	result_t     res [MAX_RES];
	logic [1:0]  res_n;
	logic [1:0]  push_n;
	logic        fire;
	logic        pop;
	result_t     head;
	logic [2:0]  count;

	// room for the worst case of three results; depends on registers only
	assign fire     = v_s1 && (count <= 3'd1);
	assign s_tready = !v_s1 || fire;
	assign pop      = m_tvalid && m_tready;
	assign push_n   = fire ? res_n : 2'd0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (s_tready) begin
			v_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			char_s1 <= s_tdata;
			end_s1  <= s_tlast;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= '0;
		end else if (fire) begin
			state_q <= state_d;
		end
	end

	cmt_step u_step (
		.char_in     (char_s1),
		.end_of_text (end_s1),
		.cur         (state_q),
		.nxt         (state_d),
		.res         (res),
		.res_n       (res_n)
	);

	cmt_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push_data (res),
		.push_n    (push_n),
		.pop       (pop),
		.head      (head),
		.count     (count)
	);

	assign m_tvalid = (count != 3'd0);
	assign m_tdata  = head.command_byte;
	assign m_tuser  = head.bad_char;
	assign m_tlast  = head.run_end;

`ifndef SYNTHESIS
	// queue never overfills
	a_queue_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count <= 3'(Q_DEPTH))
		else $error("result queue overflow");

	// an error item carries no command and closes its character's results
	a_error_item: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tuser) |-> ((m_tdata == 8'd0) && m_tlast))
		else $error("malformed error item");

	// end of text leaves nothing pending or accumulated
	a_flush_clears: assert property (@(posedge clk) disable iff (!arst_n)
		(fire && end_s1) |=> (!state_q.pend_valid && (state_q.acc.near_turns == 2'd0) &&
		                     (state_q.acc.far_turns == 2'd0)))
		else $error("state not cleared after end of text");

	// a face with no turns is held as zero
	a_empty_face: assert property (@(posedge clk) disable iff (!arst_n)
		((state_q.acc.near_turns != 2'd0) || (state_q.acc.near_face == 3'd0)) &&
		((state_q.acc.far_turns != 2'd0) || (state_q.acc.far_face == 3'd0)))
		else $error("empty face not cleared");
`endif

endmodule

// ----- tb/cube_move_command_translator_tb.sv -----
// ----------------------------------------------------------------------------
// cube_move_command_translator_tb
// Self-checking bench for the move notation translator. Sends notation
// characters over the s_ stream, predicts the command items in a tracking
// model of the accumulator, and checks each m_ item against them in order.
// ----------------------------------------------------------------------------
module cube_move_command_translator_tb;
	import cmt_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	// face numbering used by the block: U0 R1 F2 D3 L4 B5, axis = face mod 3
	localparam logic [2:0] FACE_U = 3'd0;
	localparam logic [2:0] FACE_R = 3'd1;
	localparam logic [2:0] FACE_F = 3'd2;
	localparam logic [2:0] FACE_D = 3'd3;
	localparam logic [2:0] FACE_L = 3'd4;
	localparam logic [2:0] FACE_B = 3'd5;
	localparam int AXIS_UD = 0;
	localparam int AXIS_LR = 1;
	localparam int AXIS_FB = 2;

	// command alphabets: FB a..o, LR p..z then A..D, UD E..S
	localparam logic [7:0] CMD_FB_FIRST = "a";
	localparam logic [7:0] CMD_LR_FIRST = "p";
	localparam logic [7:0] CMD_LR_WRAP  = "A";
	localparam int         CMD_LR_SPLIT = 11;
	localparam logic [7:0] CMD_UD_FIRST = "E";
	localparam logic [7:0] CMD_ERROR    = 8'h00;

	localparam logic [7:0] CH_SPACE = " ";
	localparam logic [7:0] CH_TAB   = 8'd9;
	localparam logic [7:0] CH_CR    = 8'd13;
	localparam logic [7:0] CASE_GAP = 8'd32;

	localparam int HOLD_CYCLES  = 300;
	localparam int RANDOM_CHARS = 370;
	localparam int DRAIN_CYCLES = 20;

	logic       clk;
	logic       arst_n;
	logic       s_tvalid;
	logic       s_tready;
	logic [7:0] s_tdata;
	logic       s_tlast;
	logic       m_tvalid;
	logic       m_tready;
	logic [7:0] m_tdata;
	logic       m_tuser;
	logic       m_tlast;

	cube_move_command_translator dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),   // [7:0] char_in
		.s_tlast  (s_tlast),   // end_of_text
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),   // [7:0] command_byte
		.m_tuser  (m_tuser),   // [0] bad_char
		.m_tlast  (m_tlast)    // run_end
	);

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	// tracking copy of the translator: open face letter plus accumulator
	xlat_state_t shadow;
	result_t     expected_cmds[$];
	int          mismatches;
	int          chars_sent;
	bit          idle_en;
	bit          hold_req;

	// mostly no gap, some short ones, a few long ones
	function automatic int idle_cycles();
		int r;
		r = $urandom_range(0, 99);
		if (!idle_en || r < 60)
			return 0;
		if (r < 92)
			return $urandom_range(1, 3);
		return $urandom_range(6, 24);
	endfunction

	function automatic int face_of(logic [7:0] c);
		case (c)
			"U": return FACE_U;
			"R": return FACE_R;
			"F": return FACE_F;
			"D": return FACE_D;
			"L": return FACE_L;
			"B": return FACE_B;
			default: return -1;
		endcase
	endfunction

	function automatic logic [7:0] face_char(logic [2:0] f);
		case (f)
			FACE_U: return "U";
			FACE_R: return "R";
			FACE_F: return "F";
			FACE_D: return "D";
			FACE_L: return "L";
			default: return "B";
		endcase
	endfunction

	// command letter of a non-empty accumulator
	function automatic logic [7:0] command_of(accum_t a);
		int axis;
		int idx;
		axis = (a.near_turns != 0) ? int'(a.near_face) % 3 : int'(a.far_face) % 3;
		if (a.far_turns == 0)
			idx = int'(a.near_turns) - 1;
		else
			idx = 3 + (int'(a.far_turns) - 1) * 4
				+ ((a.near_turns == 0) ? 3 : int'(a.near_turns) - 1);
		case (axis)
			AXIS_UD: return 8'(CMD_UD_FIRST + idx);
			AXIS_LR: return (idx < CMD_LR_SPLIT) ? 8'(CMD_LR_FIRST + idx)
				: 8'(CMD_LR_WRAP + (idx - CMD_LR_SPLIT));
			default: return 8'(CMD_FB_FIRST + idx);
		endcase
	endfunction

	function automatic void push_cmd(logic [7:0] cmd, logic bad);
		result_t r;
		r.command_byte = cmd;
		r.bad_char     = bad;
		r.run_end      = 1'b0;
		expected_cmds.push_back(r);
	endfunction

	// fold one turn into the accumulator, pushing it out first if it clashes
	function automatic void fold_turn(logic [2:0] f, logic [1:0] t);
		bit near_side;
		bit clash;
		int axis;
		near_side = (f == FACE_U || f == FACE_F || f == FACE_L);
		axis = int'(f) % 3;
		if (near_side)
			clash = (shadow.acc.near_turns != 0 && shadow.acc.near_face != f)
				|| (shadow.acc.far_turns != 0 && int'(shadow.acc.far_face) % 3 != axis);
		else
			clash = (shadow.acc.far_turns != 0 && shadow.acc.far_face != f)
				|| (shadow.acc.near_turns != 0 && int'(shadow.acc.near_face) % 3 != axis);
		if (clash) begin
			push_cmd(command_of(shadow.acc), 1'b0);
			shadow.acc = '0;
		end
		if (near_side) begin
			if (shadow.acc.near_turns == 0) begin
				shadow.acc.near_face  = f;
				shadow.acc.near_turns = t;
			end else begin
				shadow.acc.near_turns = shadow.acc.near_turns + t;
				if (shadow.acc.near_turns == 0)
					shadow.acc.near_face = '0;
			end
		end else begin
			if (shadow.acc.far_turns == 0) begin
				shadow.acc.far_face  = f;
				shadow.acc.far_turns = t;
			end else begin
				shadow.acc.far_turns = shadow.acc.far_turns + t;
				if (shadow.acc.far_turns == 0)
					shadow.acc.far_face = '0;
			end
		end
	endfunction

	// expected command items for one accepted character
	function automatic void translate_char(logic [7:0] c, logic last);
		int      n0;
		int      fu;
		int      fl;
		logic [1:0] t;
		bit      used;
		result_t r;
		n0 = expected_cmds.size();
		used = 1'b0;
		if (shadow.pend_valid) begin
			case (c)
				"1", "+":      t = 2'd1;
				"2":           t = 2'd2;
				"'", "3", "-": t = 2'd3;
				default:       t = 2'd0;
			endcase
			shadow.pend_valid = 1'b0;
			// a non-suffix character closes the open face as a quarter turn
			fold_turn(shadow.pend_face, (t != 0) ? t : 2'd1);
			used = (t != 0);
			shadow.pend_face = '0;
		end
		if (!used && c != CH_SPACE && !(c >= CH_TAB && c <= CH_CR)) begin
			fu = face_of(c);
			fl = (c >= "a" && c <= "z") ? face_of(c - CASE_GAP) : -1;
			if (fu >= 0) begin
				shadow.pend_valid = 1'b1;
				shadow.pend_face  = fu[2:0];
			end else if (fl >= 0) begin
				fold_turn(fl[2:0], 2'd3);
			end else begin
				// bad character: accumulator lost, one error item closes the run
				shadow = '0;
				r.command_byte = CMD_ERROR;
				r.bad_char     = 1'b1;
				r.run_end      = 1'b1;
				expected_cmds.push_back(r);
				return;
			end
		end
		if (last) begin
			if (shadow.pend_valid) begin
				shadow.pend_valid = 1'b0;
				fold_turn(shadow.pend_face, 2'd1);
			end
			if (shadow.acc.near_turns != 0 || shadow.acc.far_turns != 0)
				push_cmd(command_of(shadow.acc), 1'b0);
			shadow = '0;
		end
		if (expected_cmds.size() > n0) begin
			r = expected_cmds.pop_back();
			r.run_end = 1'b1;
			expected_cmds.push_back(r);
		end
	endfunction

	// offer one character; valid stays high into the next call when no gap
	task automatic send_char(logic [7:0] c, logic last);
		int gap;
		gap = idle_cycles();
		@(negedge clk);
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= c;
		s_tlast  <= last;
		do
			@(posedge clk);
		while (!s_tready);
		translate_char(c, last);
		chars_sent++;
	endtask

	task automatic send_text(string s, bit close);
		for (int i = 0; i < s.len(); i++)
			send_char(s[i], close && (i == s.len() - 1));
	endtask

	// result checker: oldest expectation against each accepted item
	always @(posedge clk) begin
		result_t e;
		if (arst_n && m_tvalid && m_tready) begin
			if (expected_cmds.size() == 0) begin
				$display("%0t: unexpected item: got cmd %h bad %b last %b",
					$time, m_tdata, m_tuser, m_tlast);
				mismatches++;
			end else begin
				e = expected_cmds.pop_front();
				if (m_tdata !== e.command_byte) begin
					$display("%0t: command_byte exp %h got %h", $time, e.command_byte, m_tdata);
					mismatches++;
				end
				if (m_tuser !== e.bad_char) begin
					$display("%0t: bad_char exp %b got %b", $time, e.bad_char, m_tuser);
					mismatches++;
				end
				if (m_tlast !== e.run_end) begin
					$display("%0t: run_end exp %b got %b", $time, e.run_end, m_tlast);
					mismatches++;
				end
			end
		end
	end

	// receiver: random stalls, or one long hold-off when asked
	initial begin
		int stall;
		m_tready = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_req) begin
				m_tready <= 1'b0;
				repeat (HOLD_CYCLES) @(negedge clk);
				hold_req = 1'b0;
			end else begin
				stall = idle_cycles();
				if (stall > 0) begin
					m_tready <= 1'b0;
					repeat (stall) @(negedge clk);
				end
				m_tready <= 1'b1;
			end
		end
	end

	// same-face sums, cancellation, opposite pairs, clashes, up to 3 items
	task automatic test_merging();
		send_text("F+B-f", 1'b1);  // near F cancels to zero, B' left
		send_text("U1R", 1'b1);    // last char pushes out U, then flushes R
		send_text("URf", 1'b1);    // three items on the final character
		send_text("L2R'", 1'b1);   // opposite pair, closed on a suffix
		send_text("Uu", 1'b1);     // cancels fully: empty flush, no item
	endtask

	task automatic test_invalid_chars();
		send_text("R3l'", 1'b1);   // suffix after lowercase is an error, with end
		send_text("Lx", 1'b1);     // open face closed, then dropped by the error
		send_char(8'h00, 1'b0);
		send_char(8'hFF, 1'b0);
	endtask

	task automatic test_whitespace();
		send_text("\t D\015", 1'b1);  // open face closed by whitespace with end
	endtask

	// hold the receiver off so the result queue fills and s_tready drops
	task automatic test_backpressure();
		string s;
		s = "";
		for (int i = 0; i < 14; i++)
			s = {s, "urf"};
		idle_en  = 1'b0;
		hold_req = 1'b1;
		send_text(s, 1'b1);
		idle_en  = 1'b1;
	endtask

	// well-formed strings biased toward one axis, with some noise mixed in
	task automatic test_random();
		logic [7:0] txt[$];
		logic [2:0] f;
		logic [2:0] prev;
		string      sfx;
		int         kind;
		sfx  = "1+2'3-";
		prev = FACE_U;
		while (chars_sent < RANDOM_CHARS) begin
			txt.delete();
			idle_en = ($urandom_range(0, 4) != 0);
			repeat ($urandom_range(1, 10)) begin
				if ($urandom_range(0, 1))
					f = 3'((int'(prev) + ($urandom_range(0, 1) ? 3 : 0)) % 6);
				else
					f = 3'($urandom_range(0, 5));
				prev = f;
				kind = $urandom_range(0, 19);
				if (kind < 8) begin
					txt.push_back(face_char(f));
				end else if (kind < 14) begin
					txt.push_back(face_char(f));
					txt.push_back(sfx[$urandom_range(0, 5)]);
				end else if (kind < 18) begin
					txt.push_back(face_char(f) + CASE_GAP);
				end else begin
					txt.push_back(8'($urandom_range(0, 255)));
				end
				if ($urandom_range(0, 4) == 0)
					txt.push_back(($urandom_range(0, 5) == 0) ? CH_SPACE
						: 8'(CH_TAB + $urandom_range(0, 4)));
			end
			for (int i = 0; i < txt.size(); i++)
				send_char(txt[i], i == txt.size() - 1);
		end
		idle_en = 1'b1;
	endtask

	initial begin
		arst_n     = 1'b0;
		s_tvalid   = 1'b0;
		s_tdata    = '0;
		s_tlast    = 1'b0;
		shadow     = '0;
		mismatches = 0;
		chars_sent = 0;
		idle_en    = 1'b1;
		hold_req   = 1'b0;
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		test_merging();
		test_invalid_chars();
		test_whitespace();
		test_backpressure();
		test_random();

		@(negedge clk);
		s_tvalid <= 1'b0;
		while (expected_cmds.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatches == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

	// watchdog, far above the slowest legal run
	initial begin
		#5_000_000;
		$display("CHECK FAILED");
		$finish;
	end

endmodule
